[design/bcr_pkg.sv]
// shared types, constants and register codes of the crop-and-resize block
package bcr_pkg;

  localparam int COORD_W = 9;
  localparam int PIX_W = 32;
  localparam int OUT_W = 8;
  localparam int CFG_W = 10;
  localparam int IDX_W = 3;
  localparam int QN_W = 25;
  localparam int RN_W = 9;

  localparam int MAX_DST_SIZE = 256;
  localparam int DEF_MAX_SRC_WIDTH = 512;
  localparam int DEF_MAX_SRC_HEIGHT = 512;

  localparam int RST_SRC_WIDTH = 512;
  localparam int RST_SRC_HEIGHT = 512;
  localparam int RST_BOX_X = 0;
  localparam int RST_BOX_Y = 0;
  localparam int RST_BOX_SIZE = 512;
  localparam int RST_DST_WIDTH = 256;
  localparam int RST_DST_HEIGHT = 256;

  localparam logic [QN_W-1:0] QN_RST = QN_W'((RST_BOX_SIZE * 32768) / RST_DST_WIDTH);
  localparam logic [RN_W-1:0] RN_RST = RN_W'((RST_BOX_SIZE * 32768) % RST_DST_WIDTH);

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_BOX_X,
    REG_BOX_Y,
    REG_BOX_SIZE,
    REG_DST_WIDTH,
    REG_DST_HEIGHT
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_STORE,
    KIND_ERR,
    KIND_CALC
  } kind_t;

  typedef struct packed {
    logic [9:0] src_width;
    logic [9:0] src_height;
    logic [8:0] box_x;
    logic [8:0] box_y;
    logic [9:0] box_size;
    logic [8:0] dst_width;
    logic [8:0] dst_height;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pixel;
  } item_t;

  typedef struct packed {
    logic [QN_W-1:0] qn;
    logic [RN_W-1:0] rn;
    logic            busy;
  } scale_t;

endpackage

[design/bcr_scale.sv]
// scale divider: box_size * 2^15 / dst_width, one quotient bit per cycle
module bcr_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [9:0]           box_size,
  input  logic [8:0]           dst_width,
  output bcr_pkg::scale_t      scale
);
  import bcr_pkg::*;

  logic [QN_W-1:0] dvd;
  logic [RN_W-1:0] rem;
  logic [RN_W-1:0] rem_next;
  logic [4:0]      cnt;
  logic            busy;
  logic [RN_W:0]   t;
  logic            ge;

  always_comb begin
    t = {rem, dvd[QN_W-1]};
    ge = t >= {1'b0, dst_width};
    rem_next = ge ? RN_W'(t - {1'b0, dst_width}) : t[RN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      dvd <= QN_RST;
      rem <= RN_RST;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 5'(QN_W);
      dvd <= {box_size, 15'b0};
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[QN_W-2:0], ge};
      rem <= rem_next;
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign scale.qn = dvd;
  assign scale.rn = rem;
  assign scale.busy = busy;

endmodule

[design/bcr_front.sv]
// input side: accepts words, classifies them and queues them for the engine; stores outside the frame are dropped
module bcr_front #(
  parameter int MAX_SRC_WIDTH = bcr_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = bcr_pkg::DEF_MAX_SRC_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bcr_pkg::cfg_t               cfg,
  input  logic                        hold,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [bcr_pkg::COORD_W-1:0] col,
  input  logic [bcr_pkg::COORD_W-1:0] row,
  input  logic [bcr_pkg::PIX_W-1:0]   pixel_in,
  input  logic                        pop,
  output bcr_pkg::item_t              head,
  output logic                        head_valid
);
  import bcr_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  item_t       q [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;
  logic          accept;
  logic          push;
  logic          in_range;
  logic          bad;
  item_t         item;

  assign in_stall = (cnt == (PW+1)'(DEPTH)) || hold;
  assign accept = in_valid && !in_stall;

  always_comb begin
    in_range = (32'(col) < MAX_SRC_WIDTH) && (32'(row) < MAX_SRC_HEIGHT);
    bad = (cfg.box_size == '0) || (col >= cfg.dst_width) || (row >= cfg.dst_height) ||
          (32'(col) >= MAX_DST_SIZE) || (32'(row) >= MAX_DST_SIZE);
    item.kind = !action ? KIND_STORE : (bad ? KIND_ERR : KIND_CALC);
    item.col = col;
    item.row = row;
    item.pixel = pixel_in;
    push = accept && (action || in_range);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + PW'(1);
      end
      if (pop) begin
        rp <= rp + PW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + (PW+1)'(1);
      end else if (pop && !push) begin
        cnt <= cnt - (PW+1)'(1);
      end
    end
  end

  assign head = q[rp];
  assign head_valid = cnt != '0;

endmodule

[design/bcr_back.sv]
// engine: frame store, coordinate mapping, neighbour reads and bilinear blend
module bcr_back #(
  parameter int MAX_SRC_WIDTH = bcr_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = bcr_pkg::DEF_MAX_SRC_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bcr_pkg::cfg_t             cfg,
  input  bcr_pkg::scale_t           scale,
  input  bcr_pkg::item_t            head,
  input  logic                      head_valid,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bcr_pkg::PIX_W-1:0] pixel_out,
  output logic [bcr_pkg::OUT_W-1:0] out_col,
  output logic [bcr_pkg::OUT_W-1:0] out_row,
  output logic                      error
);
  import bcr_pkg::*;

  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int XW = $clog2(MAX_SRC_WIDTH);
  localparam int YW = $clog2(MAX_SRC_HEIGHT);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE, ST_DIV, ST_MAP, ST_RD, ST_HB, ST_VB, ST_OUT
  } state_t;

  state_t state;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;

  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;
  logic               err_r;
  logic [25:0]        pq_x, pq_y;
  logic [17:0]        rem_x, rem_y;
  logic [17:0]        rem_x_next, rem_y_next;
  logic [8:0]         dq_x, dq_y;
  logic [8:0]         dq_x_next, dq_y_next;
  logic [16:0]        dvs;
  logic [2:0]         cnt;
  logic [XW-1:0]      x0, x1;
  logic [YW-1:0]      y0, y1;
  logic [15:0]        fx, fy;
  logic [PIX_W-1:0]   pix [4];
  logic [23:0]        top [4];
  logic [23:0]        bot [4];
  logic [39:0]        vs [4];

  logic [27:0] bias_x, bias_y;
  logic [25:0] map_x, map_y;
  logic [23:0] top_next [4];
  logic [23:0] bot_next [4];
  logic [39:0] vs_next [4];
  logic [16:0] wx0, wy0;
  logic [XW-1:0] rx;
  logic [YW-1:0] ry;

  function automatic logic [12:0] sat_lim(input logic [9:0] v, input int mx);
    logic [12:0] r;
    if (v == '0) begin
      r = 13'd1;
    end else if (32'(v) > mx) begin
      r = 13'(mx);
    end else begin
      r = 13'(v);
    end
    return r;
  endfunction

  // returns {clamped low neighbour, clamped high neighbour}
  function automatic logic [25:0] clamp_pair(input logic [27:0] biased,
                                             input logic [12:0] lim);
    logic [12:0] base;
    logic [12:0] lo;
    logic [12:0] hi;
    base = {1'b0, biased[27:16]};
    lo = (base == '0) ? 13'd0 : base - 13'd1;
    hi = base;
    if (lo > lim - 13'd1) begin
      lo = lim - 13'd1;
    end
    if (hi > lim - 13'd1) begin
      hi = lim - 13'd1;
    end
    return {lo, hi};
  endfunction

  // three quotient bits per cycle of the remainder correction
  always_comb begin
    logic [17:0] d;
    rem_x_next = rem_x;
    rem_y_next = rem_y;
    dq_x_next = dq_x;
    dq_y_next = dq_y;
    for (int j = 0; j < 3; j++) begin
      d = 18'(dvs >> j);
      if (rem_x_next >= d) begin
        rem_x_next = rem_x_next - d;
        dq_x_next = {dq_x_next[7:0], 1'b1};
      end else begin
        dq_x_next = {dq_x_next[7:0], 1'b0};
      end
      if (rem_y_next >= d) begin
        rem_y_next = rem_y_next - d;
        dq_y_next = {dq_y_next[7:0], 1'b1};
      end else begin
        dq_y_next = {dq_y_next[7:0], 1'b0};
      end
    end
  end

  always_comb begin
    bias_x = {3'b0, cfg.box_x, 16'b0} + 28'(pq_x + 26'(dq_x)) + 28'd32768;
    bias_y = {3'b0, cfg.box_y, 16'b0} + 28'(pq_y + 26'(dq_y)) + 28'd32768;
    map_x = clamp_pair(bias_x, sat_lim(cfg.src_width, MAX_SRC_WIDTH));
    map_y = clamp_pair(bias_y, sat_lim(cfg.src_height, MAX_SRC_HEIGHT));
  end

  always_comb begin
    wx0 = 17'h10000 - 17'(fx);
    wy0 = 17'h10000 - 17'(fy);
    for (int c = 0; c < 4; c++) begin
      top_next[c] = 24'(25'(pix[0][8*c +: 8]) * 25'(wx0) + 25'(pix[1][8*c +: 8]) * 25'(fx));
      bot_next[c] = 24'(25'(pix[2][8*c +: 8]) * 25'(wx0) + 25'(pix[3][8*c +: 8]) * 25'(fx));
      vs_next[c] = 40'(top[c]) * 40'(wy0) + 40'(bot[c]) * 40'(fy) + 40'h0080000000;
    end
  end

  always_comb begin
    rx = (cnt[0] == 1'b0) ? x0 : x1;
    ry = (cnt[1] == 1'b0) ? y0 : y1;
    rd_addr = AW'(32'(ry) * MAX_SRC_WIDTH + 32'(rx));
    pop = (state == ST_IDLE) && head_valid;
    wr_en = pop && (head.kind == KIND_STORE);
    addr = wr_en ? AW'(32'(head.row) * MAX_SRC_WIDTH + 32'(head.col)) : rd_addr;
  end

  // single-port frame store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= head.pixel;
    end else begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head_valid) begin
            col_r <= head.col;
            row_r <= head.row;
            case (head.kind)
              KIND_ERR: begin
                err_r <= 1'b1;
                state <= ST_OUT;
              end
              KIND_CALC: begin
                err_r <= 1'b0;
                state <= ST_PRE;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_PRE: begin
          pq_x <= 26'(26'({col_r, 1'b1}) * 26'(scale.qn));
          pq_y <= 26'(26'({row_r, 1'b1}) * 26'(scale.qn));
          rem_x <= 18'(18'({col_r, 1'b1}) * 18'(scale.rn));
          rem_y <= 18'(18'({row_r, 1'b1}) * 18'(scale.rn));
          dq_x <= '0;
          dq_y <= '0;
          dvs <= {cfg.dst_width, 8'b0};
          cnt <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem_x <= rem_x_next;
          rem_y <= rem_y_next;
          dq_x <= dq_x_next;
          dq_y <= dq_y_next;
          dvs <= dvs >> 3;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd2) begin
            state <= ST_MAP;
          end
        end
        ST_MAP: begin
          x0 <= map_x[13 +: XW];
          x1 <= map_x[0 +: XW];
          y0 <= map_y[13 +: YW];
          y1 <= map_y[0 +: YW];
          fx <= bias_x[15:0];
          fy <= bias_y[15:0];
          cnt <= '0;
          state <= ST_RD;
        end
        ST_RD: begin
          if (cnt != 3'd0) begin
            pix[2'(cnt - 3'd1)] <= rdata;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= ST_HB;
          end
        end
        ST_HB: begin
          for (int c = 0; c < 4; c++) begin
            top[c] <= top_next[c];
            bot[c] <= bot_next[c];
          end
          state <= ST_VB;
        end
        ST_VB: begin
          for (int c = 0; c < 4; c++) begin
            vs[c] <= vs_next[c];
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            pixel_out <= err_r ? '0 : {vs[3][39:32], vs[2][39:32], vs[1][39:32], vs[0][39:32]};
            out_col <= col_r[OUT_W-1:0];
            out_row <= row_r[OUT_W-1:0];
            error <= err_r;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/bilinear_crop_resize.sv]
// top level of the crop-and-resize block: registers, scale divider, queue and engine
//
//  channel | handshake                | word
//  --------+--------------------------+-----------------------------------
//  in      | in_valid / in_stall      | action, col, row, pixel_in
//  out     | out_valid / out_stall    | pixel_out, out_col, out_row, error
//  cfg     | cfg_we                   | cfg_index, cfg_data
//
//  a store is written straight from the idle state and a rejected query goes to the output;
//  a computed pixel takes one multiply, the quotient correction, one map, the reads of the
//  four neighbours on the single frame store port, two blend stages and the output register
//  the input queue holds 4 words, so input keeps flowing while the engine works
//  a write to box_size or dst_width stalls input while the scale is divided
//  rst is synchronous; the frame store is not cleared
module bilinear_crop_resize #(
  parameter int MAX_SRC_WIDTH = bcr_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = bcr_pkg::DEF_MAX_SRC_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [bcr_pkg::COORD_W-1:0] col,
  input  logic [bcr_pkg::COORD_W-1:0] row,
  input  logic [bcr_pkg::PIX_W-1:0]   pixel_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bcr_pkg::PIX_W-1:0]   pixel_out,
  output logic [bcr_pkg::OUT_W-1:0]   out_col,
  output logic [bcr_pkg::OUT_W-1:0]   out_row,
  output logic                        error,
  input  logic                        cfg_we,
  input  logic [bcr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bcr_pkg::CFG_W-1:0]   cfg_data
);
  import bcr_pkg::*;

  cfg_t   cfg;
  scale_t scale;
  item_t  head;
  logic   head_valid;
  logic   pop;
  logic   kick;
  logic   hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width <= 10'(RST_SRC_WIDTH);
      cfg.src_height <= 10'(RST_SRC_HEIGHT);
      cfg.box_x <= 9'(RST_BOX_X);
      cfg.box_y <= 9'(RST_BOX_Y);
      cfg.box_size <= 10'(RST_BOX_SIZE);
      cfg.dst_width <= 9'(RST_DST_WIDTH);
      cfg.dst_height <= 9'(RST_DST_HEIGHT);
      kick <= 1'b0;
    end else begin
      kick <= cfg_we && (cfg_index == REG_BOX_SIZE || cfg_index == REG_DST_WIDTH);
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_SRC_WIDTH:  cfg.src_width <= cfg_data;
          REG_SRC_HEIGHT: cfg.src_height <= cfg_data;
          REG_BOX_X:      cfg.box_x <= cfg_data[8:0];
          REG_BOX_Y:      cfg.box_y <= cfg_data[8:0];
          REG_BOX_SIZE:   cfg.box_size <= cfg_data;
          REG_DST_WIDTH:  cfg.dst_width <= cfg_data[8:0];
          REG_DST_HEIGHT: cfg.dst_height <= cfg_data[8:0];
          default: ;
        endcase
      end
    end
  end

  assign hold = kick || scale.busy;

  bcr_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .start     (kick),
    .box_size  (cfg.box_size),
    .dst_width (cfg.dst_width),
    .scale     (scale)
  );

  bcr_front #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .hold       (hold),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .col        (col),
    .row        (row),
    .pixel_in   (pixel_in),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  bcr_back #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .scale      (scale),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .out_col    (out_col),
    .out_row    (out_row),
    .error      (error)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> pixel_out == '0)
    else $error("rejected query carries a nonzero pixel");

  a_scale_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_BOX_SIZE || cfg_index == REG_DST_WIDTH) |=> in_stall)
    else $error("input taken while scale is being recomputed");

  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

[test/testbench.sv]
// self-checking testbench for the bilinear crop-and-resize block
module testbench;
  import bcr_pkg::*;

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_CALC = 1'b1;
  localparam int FRAME_W = 512;
  localparam int FRAME_H = 512;

  typedef struct {
    logic [31:0] pixel;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        err;
  } pix_res_t;

  typedef struct {
    logic        act;
    logic [8:0]  col;
    logic [8:0]  row;
    logic [31:0] pixel;
    logic        typed;
    logic [31:0] exp_pixel;
    logic        exp_err;
  } stim_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic action;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [PIX_W-1:0] pixel_in;
  logic out_valid;
  logic out_stall;
  logic [PIX_W-1:0] pixel_out;
  logic [OUT_W-1:0] out_col;
  logic [OUT_W-1:0] out_row;
  logic error;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  logic [31:0] frame_mem [FRAME_W*FRAME_H];
  bit written [FRAME_W*FRAME_H];
  pix_res_t pending_px[$];

  longint unsigned src_w, src_h, bx, by, bsize, dst_w, dst_h;
  int in_idle_pct;
  int out_stall_pct;
  int words_sent;
  int results_seen;
  int mismatches;
  int hold_left;
  bit hold_done;

  bilinear_crop_resize i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .col(col), .row(row), .pixel_in(pixel_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_out(pixel_out), .out_col(out_col), .out_row(out_row), .error(error),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void map_axis(longint unsigned d, longint unsigned box,
                                   longint unsigned lim, output longint unsigned n0,
                                   output longint unsigned n1, output longint unsigned f);
    longint unsigned q, biased, base;
    q = (((2 * d + 1) * bsize) << 16) / (2 * dst_w);
    biased = (box << 16) + q + 32768;
    base = biased >> 16;
    n0 = (base == 0) ? 0 : base - 1;
    n1 = base;
    if (n0 > lim - 1) n0 = lim - 1;
    if (n1 > lim - 1) n1 = lim - 1;
    f = biased & 16'hFFFF;
  endfunction

  function automatic longint unsigned sat_size(longint unsigned v, longint unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit query_rejected(logic [8:0] c, logic [8:0] r);
    longint unsigned dw, dh;
    dw = (dst_w < MAX_DST_SIZE) ? dst_w : MAX_DST_SIZE;
    dh = (dst_h < MAX_DST_SIZE) ? dst_h : MAX_DST_SIZE;
    return (bsize == 0 || c >= dw || r >= dh);
  endfunction

  function automatic pix_res_t calc_pixel(logic [8:0] c, logic [8:0] r);
    pix_res_t res;
    longint unsigned x0, x1, y0, y1, fx, fy, a, b, d, e, top, bot, v;
    logic [31:0] p00, p10, p01, p11;
    res.col = c[7:0];
    res.row = r[7:0];
    res.pixel = '0;
    res.err = 1'b1;
    if (query_rejected(c, r)) return res;
    res.err = 1'b0;
    map_axis(c, bx, sat_size(src_w, FRAME_W), x0, x1, fx);
    map_axis(r, by, sat_size(src_h, FRAME_H), y0, y1, fy);
    p00 = frame_mem[y0 * FRAME_W + x0];
    p10 = frame_mem[y0 * FRAME_W + x1];
    p01 = frame_mem[y1 * FRAME_W + x0];
    p11 = frame_mem[y1 * FRAME_W + x1];
    for (int ch = 0; ch < 4; ch++) begin
      a = p00[8*ch +: 8];
      b = p10[8*ch +: 8];
      d = p01[8*ch +: 8];
      e = p11[8*ch +: 8];
      top = a * (65536 - fx) + b * fx;
      bot = d * (65536 - fx) + e * fx;
      v = (top * (65536 - fy) + bot * fy + 64'h8000_0000) >> 32;
      if (v > 255) v = 255;
      res.pixel[8*ch +: 8] = v[7:0];
    end
    return res;
  endfunction

  task automatic send_word(logic act, logic [8:0] c, logic [8:0] r, logic [31:0] px,
                           bit typed, pix_res_t typed_res);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    col <= c;
    row <= r;
    pixel_in <= px;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (act == ACT_STORE) begin
      frame_mem[r * FRAME_W + c] = px;
      written[r * FRAME_W + c] = 1'b1;
    end else if (typed) begin
      pending_px.push_back(typed_res);
    end else begin
      pending_px.push_back(calc_pixel(c, r));
    end
  endtask

  // fills any unwritten neighbor before the query goes out
  task automatic send_query(logic [8:0] c, logic [8:0] r);
    longint unsigned xs[2], ys[2], fx, fy;
    pix_res_t none;
    none = '{default: '0};
    if (!query_rejected(c, r)) begin
      map_axis(c, bx, sat_size(src_w, FRAME_W), xs[0], xs[1], fx);
      map_axis(r, by, sat_size(src_h, FRAME_H), ys[0], ys[1], fy);
      foreach (ys[j]) foreach (xs[i])
        if (!written[ys[j] * FRAME_W + xs[i]])
          send_word(ACT_STORE, xs[i], ys[j], $urandom, 1'b0, none);
    end
    send_word(ACT_CALC, c, r, $urandom, 1'b0, none);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_px.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, longint unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    case (idx)
      REG_SRC_WIDTH: src_w = val & 10'h3FF;
      REG_SRC_HEIGHT: src_h = val & 10'h3FF;
      REG_BOX_X: bx = val & 9'h1FF;
      REG_BOX_Y: by = val & 9'h1FF;
      REG_BOX_SIZE: bsize = val & 10'h3FF;
      REG_DST_WIDTH: dst_w = val & 9'h1FF;
      REG_DST_HEIGHT: dst_h = val & 9'h1FF;
      default: ;
    endcase
  endtask

  task automatic write_all(longint unsigned sw, longint unsigned sh, longint unsigned x,
                           longint unsigned y, longint unsigned bs, longint unsigned dw,
                           longint unsigned dh);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_BOX_X, x);
    write_reg(REG_BOX_Y, y);
    write_reg(REG_BOX_SIZE, bs);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver side: random stall plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_sent >= 200) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    pix_res_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: pixel %h col %0d row %0d error %b",
                   pixel_out, out_col, out_row, error);
      end else begin
        want = pending_px.pop_front();
        if (pixel_out !== want.pixel || out_col !== want.col || out_row !== want.row
            || error !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%0d/%0d/%b got %h/%0d/%0d/%b", want.pixel,
                     want.col, want.row, want.err, pixel_out, out_col, out_row, error);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("[bilinear_crop_resize] ERROR");
    $finish;
  end

  initial begin
    stim_row_t dir_rows[$];
    pix_res_t typed_res;
    int seg;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_STORE;
    col = '0;
    row = '0;
    pixel_in = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    words_sent = 0;
    results_seen = 0;
    mismatches = 0;
    hold_left = 0;
    hold_done = 1'b0;
    src_w = RST_SRC_WIDTH;
    src_h = RST_SRC_HEIGHT;
    bx = RST_BOX_X;
    by = RST_BOX_Y;
    bsize = RST_BOX_SIZE;
    dst_w = RST_DST_WIDTH;
    dst_h = RST_DST_HEIGHT;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: scale two, first and last destination pixel, rejects and computed queries
    dir_rows = '{
      '{ACT_STORE, 0, 0, 32'hFFFF_FFFF, 0, 0, 0},
      '{ACT_STORE, 1, 0, 32'hFFFF_FFFF, 0, 0, 0},
      '{ACT_STORE, 0, 1, 32'hFFFF_FFFF, 0, 0, 0},
      '{ACT_STORE, 1, 1, 32'hFFFF_FFFF, 0, 0, 0},
      '{ACT_CALC, 0, 0, 0, 1, 32'hFFFF_FFFF, 0},
      '{ACT_STORE, 510, 510, 32'h0000_0000, 0, 0, 0},
      '{ACT_STORE, 511, 510, 32'h0000_0000, 0, 0, 0},
      '{ACT_STORE, 510, 511, 32'h0000_0000, 0, 0, 0},
      '{ACT_STORE, 511, 511, 32'h0000_0000, 0, 0, 0},
      '{ACT_CALC, 255, 255, 32'hFFFF_FFFF, 1, 32'h0000_0000, 0},
      '{ACT_CALC, 256, 0, 0, 1, 0, 1},
      '{ACT_CALC, 0, 256, 0, 1, 0, 1},
      '{ACT_CALC, 511, 511, 32'hFFFF_FFFF, 1, 0, 1},
      '{ACT_STORE, 300, 200, 32'h1234_5678, 0, 0, 0},
      '{ACT_STORE, 511, 0, 32'hA5A5_5A5A, 0, 0, 0},
      '{ACT_CALC, 10, 20, 0, 0, 0, 0},
      '{ACT_CALC, 150, 100, 0, 0, 0, 0},
      '{ACT_CALC, 255, 0, 0, 0, 0, 0}
    };
    foreach (dir_rows[k]) begin
      typed_res.pixel = dir_rows[k].exp_pixel;
      typed_res.col = dir_rows[k].col[7:0];
      typed_res.row = dir_rows[k].row[7:0];
      typed_res.err = dir_rows[k].exp_err;
      if (dir_rows[k].act == ACT_CALC && !dir_rows[k].typed)
        send_query(dir_rows[k].col, dir_rows[k].row);
      else
        send_word(dir_rows[k].act, dir_rows[k].col, dir_rows[k].row, dir_rows[k].pixel,
                  dir_rows[k].typed, typed_res);
    end
    drain();

    for (seg = 0; seg < 8; seg++) begin
      case (seg)
        0: write_all(1, 1, 0, 0, 1, 1, 1);
        1: write_all(512, 512, 511, 511, 512, 256, 256);
        2: write_all(0, 1023, 5, 9, 0, 16, 16);
        3: write_all(1023, 0, 100, 40, 1023, 0, 511);
        4: write_all(64, 48, 7, 3, 40, 511, 20);
        5: write_all(16, 16, 0, 0, 16, 32, 32);
        default: write_all($urandom_range(1, 512), $urandom_range(1, 512),
                           $urandom_range(511), $urandom_range(511),
                           $urandom_range(1, 512), $urandom_range(1, 256),
                           $urandom_range(1, 256));
      endcase
      case (seg % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 64; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 64; end
        default: begin in_idle_pct = 7; out_stall_pct = 7; end
      endcase
      repeat (80) begin
        if ($urandom_range(3) == 0)
          send_word(ACT_STORE, $urandom_range(511), $urandom_range(511), $urandom,
                    1'b0, typed_res);
        else if ($urandom_range(9) == 0)
          send_query($urandom_range(511), $urandom_range(511));
        else
          send_query($urandom_range((dst_w > 1) ? dst_w - 1 : 0),
                     $urandom_range((dst_h > 1) ? dst_h - 1 : 0));
      end
      drain();
    end

    $display("covered %0d input words and %0d output words over 9 register settings",
             words_sent, results_seen);
    $display("with idle, stall and hold-off patterns on both channels");
    if (mismatches == 0 && pending_px.size() == 0)
      $display("[bilinear_crop_resize] OK");
    else
      $display("[bilinear_crop_resize] ERROR");
    $finish;
  end

endmodule
